// ===== design/bvaa_pkg.sv =====
// shared constants, types and register codes of the battery voltage monitor
package bvaa_pkg;

    localparam int ADC_BITS    = 12;
    localparam int RING_DEPTH  = 8;
    localparam int RING_AW     = $clog2(RING_DEPTH);
    localparam int MV_W        = 16;
    localparam int SUM_W       = MV_W + RING_AW;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int SCALE_FRAC  = 8;
    localparam int PROD_W      = ADC_BITS + CFG_W;
    localparam int DIFF_W      = PROD_W - SCALE_FRAC + 2;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_W-1:0] SCALE_RESET  = 16'd768;
    localparam logic [CFG_W-1:0] OFFSET_RESET = 16'd0;
    localparam logic [CFG_W-1:0] WARN_RESET   = 16'd11100;
    localparam logic [CFG_W-1:0] STOP_RESET   = 16'd10500;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCALE  = 2'd0,
        CFG_OFFSET = 2'd1,
        CFG_WARN   = 2'd2,
        CFG_STOP   = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        ALERT_NONE = 2'd0,
        ALERT_WARN = 2'd1,
        ALERT_CRIT = 2'd2
    } alert_t;

    typedef struct packed {
        logic        [CFG_W-1:0] scale_q8;
        logic signed [MV_W-1:0]  offset_mv;
        logic signed [MV_W-1:0]  warn_mv;
        logic signed [MV_W-1:0]  stop_mv;
    } cfg_t;

endpackage

// ===== design/bvaa_if.sv =====
// item channels: raw converter samples in, averaged results out
interface bvaa_sample_if;
    logic                         valid;
    logic                         ready;
    logic [bvaa_pkg::ADC_BITS-1:0] adc_code;

    modport source (output valid, output adc_code, input ready);
    modport sink (input valid, input adc_code, output ready);
endinterface

interface bvaa_result_if;
    logic                            valid;
    logic                            ready;
    logic signed [bvaa_pkg::MV_W-1:0] average_mv;
    logic [1:0]                      alert_level;
    logic [1:0]                      new_alert;

    modport source (output valid, output average_mv, output alert_level, output new_alert,
                    input ready);
    modport sink (input valid, input average_mv, input alert_level, input new_alert,
                  output ready);
endinterface

// ===== design/bvaa_front.sv =====
// front end: takes samples, scales them and converts to saturated millivolts
module bvaa_front
(
    input  logic                              clk,
    input  logic                              rst_n,
    bvaa_sample_if.sink                       sample,
    input  bvaa_pkg::cfg_t                    cfg,
    output logic                              push_valid,
    output logic signed [bvaa_pkg::MV_W-1:0]  push_mv,
    input  logic                              push_ready
);

    logic                              f_valid_reg;
    logic                              f_valid_next;
    logic [bvaa_pkg::PROD_W-1:0]       prod_reg;
    logic [bvaa_pkg::PROD_W-1:0]       prod_next;
    logic signed [bvaa_pkg::DIFF_W-1:0] diff;
    logic                              accept;
    logic                              overflow;

    assign sample.ready = !f_valid_reg || push_ready;
    assign accept       = sample.valid && sample.ready;

    always_comb
    begin
        prod_next = bvaa_pkg::PROD_W'(sample.adc_code) * bvaa_pkg::PROD_W'(cfg.scale_q8);
        if (accept)
        begin
            f_valid_next = 1'b1;
        end
        else if (push_ready)
        begin
            f_valid_next = 1'b0;
        end
        else
        begin
            f_valid_next = f_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else
        begin
            f_valid_reg <= f_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            prod_reg <= prod_next;
        end
    end

    // drop fraction bits, remove offset, clamp to 16 bits
    always_comb
    begin
        diff = $signed({2'b00, prod_reg[bvaa_pkg::PROD_W-1:bvaa_pkg::SCALE_FRAC]})
             - bvaa_pkg::DIFF_W'(cfg.offset_mv);
        overflow = !((&diff[bvaa_pkg::DIFF_W-1:bvaa_pkg::MV_W-1])
                  || !(|diff[bvaa_pkg::DIFF_W-1:bvaa_pkg::MV_W-1]));
        if (overflow)
        begin
            push_mv = diff[bvaa_pkg::DIFF_W-1] ? {1'b1, {(bvaa_pkg::MV_W-1){1'b0}}}
                                              : {1'b0, {(bvaa_pkg::MV_W-1){1'b1}}};
        end
        else
        begin
            push_mv = diff[bvaa_pkg::MV_W-1:0];
        end
    end

    assign push_valid = f_valid_reg;

endmodule

// ===== design/bvaa_queue.sv =====
// short queue of converted samples between front end and back end
module bvaa_queue
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push_valid,
    input  logic signed [bvaa_pkg::MV_W-1:0]  push_mv,
    output logic                              push_ready,
    output logic                              pop_valid,
    output logic signed [bvaa_pkg::MV_W-1:0]  pop_mv,
    input  logic                              pop_ready
);

    logic signed [bvaa_pkg::MV_W-1:0] mem_reg [bvaa_pkg::QUEUE_DEPTH];
    logic [bvaa_pkg::QUEUE_AW-1:0]    wr_ptr_reg;
    logic [bvaa_pkg::QUEUE_AW-1:0]    wr_ptr_next;
    logic [bvaa_pkg::QUEUE_AW-1:0]    rd_ptr_reg;
    logic [bvaa_pkg::QUEUE_AW-1:0]    rd_ptr_next;
    logic [bvaa_pkg::QUEUE_CW-1:0]    count_reg;
    logic [bvaa_pkg::QUEUE_CW-1:0]    count_next;
    logic                             push;
    logic                             pop;

    assign push_ready = count_reg != bvaa_pkg::QUEUE_CW'(bvaa_pkg::QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_mv     = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == bvaa_pkg::QUEUE_AW'(bvaa_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == bvaa_pkg::QUEUE_AW'(bvaa_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_mv;
        end
    end

endmodule

// ===== design/bvaa_back.sv =====
// back end: sample ring, running sum, average and latched alert level
module bvaa_back
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              pop_valid,
    input  logic signed [bvaa_pkg::MV_W-1:0]  pop_mv,
    output logic                              pop_ready,
    input  bvaa_pkg::cfg_t                    cfg,
    bvaa_result_if.source                     result
);

    logic signed [bvaa_pkg::MV_W-1:0]  ring_reg [bvaa_pkg::RING_DEPTH];
    logic [bvaa_pkg::RING_AW-1:0]      wp_reg;
    logic [bvaa_pkg::RING_AW-1:0]      wp_next;
    logic signed [bvaa_pkg::SUM_W-1:0] sum_reg;
    logic signed [bvaa_pkg::SUM_W-1:0] sum_next;
    logic                              primed_reg;
    logic                              primed_next;
    logic                              a_valid_reg;
    logic                              a_valid_next;
    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic signed [bvaa_pkg::MV_W-1:0]  avg_reg;
    bvaa_pkg::alert_t                  level_reg;
    bvaa_pkg::alert_t                  level_next;
    bvaa_pkg::alert_t                  raised_reg;
    bvaa_pkg::alert_t                  raised_next;
    logic signed [bvaa_pkg::MV_W-1:0]  avg;
    logic                              pop;
    logic                              a_adv;

    assign a_adv     = a_valid_reg && (!out_valid_reg || result.ready);
    assign pop_ready = !a_valid_reg || a_adv;
    assign pop       = pop_valid && pop_ready;

    // ring and sum update
    always_comb
    begin
        sum_next    = sum_reg;
        wp_next     = wp_reg;
        primed_next = primed_reg;
        if (pop)
        begin
            if (!primed_reg)
            begin
                sum_next    = {pop_mv, {bvaa_pkg::RING_AW{1'b0}}};
                primed_next = 1'b1;
            end
            else
            begin
                sum_next = sum_reg - bvaa_pkg::SUM_W'(ring_reg[wp_reg])
                         + bvaa_pkg::SUM_W'(pop_mv);
                wp_next  = (wp_reg == bvaa_pkg::RING_AW'(bvaa_pkg::RING_DEPTH - 1))
                         ? '0 : wp_reg + 1'b1;
            end
        end
        if (pop)
        begin
            a_valid_next = 1'b1;
        end
        else if (a_adv)
        begin
            a_valid_next = 1'b0;
        end
        else
        begin
            a_valid_next = a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            for (int i = 0; i < bvaa_pkg::RING_DEPTH; i++)
            begin
                if (!primed_reg || (wp_reg == bvaa_pkg::RING_AW'(i)))
                begin
                    ring_reg[i] <= pop_mv;
                end
            end
        end
    end

    // floored average, limit checks, level latch
    assign avg = sum_reg[bvaa_pkg::SUM_W-1:bvaa_pkg::RING_AW];

    always_comb
    begin
        level_next  = level_reg;
        raised_next = bvaa_pkg::ALERT_NONE;
        if (a_adv && (avg < cfg.warn_mv))
        begin
            if (avg < cfg.stop_mv)
            begin
                if (level_reg != bvaa_pkg::ALERT_CRIT)
                begin
                    level_next  = bvaa_pkg::ALERT_CRIT;
                    raised_next = bvaa_pkg::ALERT_CRIT;
                end
            end
            else if (level_reg == bvaa_pkg::ALERT_NONE)
            begin
                level_next  = bvaa_pkg::ALERT_WARN;
                raised_next = bvaa_pkg::ALERT_WARN;
            end
        end
        if (a_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            wp_reg        <= '0;
            primed_reg    <= 1'b0;
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            level_reg     <= bvaa_pkg::ALERT_NONE;
        end
        else
        begin
            sum_reg       <= sum_next;
            wp_reg        <= wp_next;
            primed_reg    <= primed_next;
            a_valid_reg   <= a_valid_next;
            out_valid_reg <= out_valid_next;
            level_reg     <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_adv)
        begin
            avg_reg    <= avg;
            raised_reg <= raised_next;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.average_mv  = avg_reg;
    assign result.alert_level = level_reg;
    assign result.new_alert   = raised_reg;

endmodule

// ===== design/battery_voltage_average_alarm.sv =====
// top level of the battery voltage moving-average undervoltage monitor
//
// sample channel takes one raw converter code per item; result channel gives
// one item per sample: floored moving average over the last eight samples in
// millivolts, the latched alert level and the level newly raised by it.
// the first sample after reset fills the whole averaging ring.
// registers are written through cfg_we / cfg_index / cfg_data; the user must
// only write them while idle, which the block does not enforce: 0 scale (q8),
// 1 offset, 2 warning limit, 3 critical limit. throughput: one item per cycle
// unless the receiver stalls; the running sum is updated once per popped
// sample in the back end and the scaling multiply sits in its own front stage.
// a two-entry queue parts the front and back ends and the output register
// holds a stalled result; samples are then taken until the back end, queue
// and front register are full, and then sample.ready drops.
// reset clears the alert level, the running sum and all pipeline state and
// restores the register defaults.
module battery_voltage_average_alarm
(
    input  logic                              clk,
    input  logic                              rst_n,
    bvaa_sample_if.sink                       sample,
    bvaa_result_if.source                     result,
    input  logic                              cfg_we,
    input  logic [bvaa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bvaa_pkg::CFG_W-1:0]        cfg_data
);

    bvaa_pkg::cfg_t                   cfg_reg;
    bvaa_pkg::cfg_t                   cfg_next;
    logic                             push_valid;
    logic signed [bvaa_pkg::MV_W-1:0] push_mv;
    logic                             push_ready;
    logic                             pop_valid;
    logic signed [bvaa_pkg::MV_W-1:0] pop_mv;
    logic                             pop_ready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (bvaa_pkg::cfg_index_t'(cfg_index))
                bvaa_pkg::CFG_SCALE:  cfg_next.scale_q8  = cfg_data;
                bvaa_pkg::CFG_OFFSET: cfg_next.offset_mv = cfg_data;
                bvaa_pkg::CFG_WARN:   cfg_next.warn_mv   = cfg_data;
                bvaa_pkg::CFG_STOP:   cfg_next.stop_mv   = cfg_data;
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.scale_q8  <= bvaa_pkg::SCALE_RESET;
            cfg_reg.offset_mv <= bvaa_pkg::OFFSET_RESET;
            cfg_reg.warn_mv   <= bvaa_pkg::WARN_RESET;
            cfg_reg.stop_mv   <= bvaa_pkg::STOP_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    bvaa_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample     (sample),
        .cfg        (cfg_reg),
        .push_valid (push_valid),
        .push_mv    (push_mv),
        .push_ready (push_ready)
    );

    bvaa_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_mv    (push_mv),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_mv     (pop_mv),
        .pop_ready  (pop_ready)
    );

    bvaa_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_mv    (pop_mv),
        .pop_ready (pop_ready),
        .cfg       (cfg_reg),
        .result    (result)
    );

endmodule

// ===== design/bvaa_checker.sv =====
// port-level checks of the monitor and their attachment to the top level
module bvaa_port_checker
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic signed [bvaa_pkg::MV_W-1:0] average_mv,
    input  logic [1:0]                      alert_level,
    input  logic [1:0]                      new_alert
);

    logic [3:0] pending_reg;
    logic [3:0] pending_next;
    logic [1:0] last_level_reg;
    logic [1:0] last_level_next;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    always_comb
    begin
        pending_next    = pending_reg + {3'b000, in_acc} - {3'b000, out_acc};
        last_level_next = out_acc ? alert_level : last_level_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg    <= '0;
            last_level_reg <= '0;
        end
        else
        begin
            pending_reg    <= pending_next;
            last_level_reg <= last_level_next;
        end
    end

    a_no_invented_item: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc |-> pending_reg != 4'd0)
        else $error("result item without a pending sample");

    a_level_never_falls: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc |-> alert_level >= last_level_reg)
        else $error("alert level fell");

    a_new_alert_matches: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && new_alert != 2'd0) |-> (alert_level == new_alert))
        else $error("raised alert differs from latched level");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(average_mv)
                                       && $stable(alert_level) && $stable(new_alert)))
        else $error("stalled result changed");

endmodule

bind battery_voltage_average_alarm bvaa_port_checker u_bvaa_port_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (sample.valid),
    .in_ready    (sample.ready),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .average_mv  (result.average_mv),
    .alert_level (result.alert_level),
    .new_alert   (result.new_alert)
);
